### hw/rtl/sfr_pkg.sv
// Shared constants and types for the framed byte receiver.
// Used by sfr_store and sync_frame_receiver_xor_check; depends on nothing.
`timescale 1ns / 1ps

package sfr_pkg;

   // frame layout
   localparam int MAX_BODY      = 128;
   localparam int HEADER_BYTES  = 8;
   localparam int ID_OFFSET     = 2;
   localparam int LENGTH_OFFSET = 4;
   localparam int CHECK_BYTES   = 2;
   localparam int SYNC_BYTES    = 2;

   // register reset values
   localparam logic [15:0] SYNC_WORD_RST    = 16'h0000;
   localparam logic [7:0]  MAX_BODY_LEN_RST = 8'd128;

   // request codes
   localparam logic [1:0] REQ_BYTE    = 2'd0;
   localparam logic [1:0] REQ_READ    = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   // result codes
   localparam logic [2:0] EV_GOOD    = 3'd0;
   localparam logic [2:0] EV_CSUM    = 3'd1;
   localparam logic [2:0] EV_LONG    = 3'd2;
   localparam logic [2:0] EV_READ    = 3'd3;
   localparam logic [2:0] EV_REFUSED = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_SYNC_WORD    = 2'd0;
   localparam logic [1:0] CSR_MAX_BODY_LEN = 2'd1;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_BODY,
      PH_LOCKED
   } phase_type;

endpackage

### hw/rtl/sfr_store.sv
// Frame byte store: one write port, one read port, registered read data.
// Depends on sfr_pkg only through the default value of its DEPTH parameter.
`timescale 1ns / 1ps

module sfr_store #(
   parameter int DEPTH = sfr_pkg::HEADER_BYTES + sfr_pkg::MAX_BODY + sfr_pkg::CHECK_BYTES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sync_frame_receiver_xor_check.sv
// Framed byte receiver with 16-bit XOR checksum, top level.
// Depends on sfr_pkg and sfr_store.
`timescale 1ns / 1ps
//
// Usage:
//  - req channel (valid/stall): one word per accepted edge. req_type selects
//    a received stream byte, a read of the frame buffer, or a release.
//  - rsp channel (valid/stall): at most one result word per request; frame
//    events (good, checksum error, length too long), read data, refused byte.
//  - csr channel (valid/ready, always ready): index 0 sync word, 1 body limit.
//    Write only while no request is in flight.
// Throughput: one request per cycle while req_stall is low. Each header or body
//  byte is a single buffer write and a byte-wide XOR update; a read is at most one buffer read port access.
// Result path: a result is registered in the read stage (with the buffer read
//  register), then in the output register, before it appears on rsp.
// Stall: results queue in the read stage and the output register; req_stall
//  rises only when both hold a result and rsp_stall is high.
// Reset: hunting for sync, error count zero, sync word 0, body limit 128. The
//  buffer is not cleared; a release makes it read as zero until rewritten.
// After a good frame, bytes are refused until release; reads are served always.

module sync_frame_receiver_xor_check #(
   parameter int MAX_BODY = sfr_pkg::MAX_BODY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_read_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_frame_id,
   output logic [15:0] rsp_body_length,
   output logic [7:0]  rsp_read_data,
   output logic [15:0] rsp_error_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int STORE_BYTES = sfr_pkg::HEADER_BYTES + MAX_BODY + sfr_pkg::CHECK_BYTES;
   localparam int AW = $clog2(STORE_BYTES);
   localparam int IW = $clog2(STORE_BYTES + 1);
   localparam int LW = $clog2(MAX_BODY + sfr_pkg::CHECK_BYTES + 1);

   localparam logic [7:0]    BODY_CAP   = 8'(MAX_BODY);
   localparam logic [IW-1:0] HDR_LAST   = IW'(sfr_pkg::HEADER_BYTES - 1);
   localparam logic [IW-1:0] HDR_BYTES  = IW'(sfr_pkg::HEADER_BYTES);
   localparam logic [IW-1:0] ID_IDX     = IW'(sfr_pkg::ID_OFFSET);
   localparam logic [IW-1:0] LEN_LO_IDX = IW'(sfr_pkg::LENGTH_OFFSET);
   localparam logic [IW-1:0] LEN_HI_IDX = IW'(sfr_pkg::LENGTH_OFFSET + 1);
   localparam logic [IW-1:0] SYNC_IDX   = IW'(sfr_pkg::SYNC_BYTES);
   localparam logic [7:0]    SYNC_OFF   = 8'(sfr_pkg::SYNC_BYTES);

   // configuration
   logic [15:0] sync_word_ff, sync_word_in;
   logic [7:0]  max_len_ff, max_len_in;

   // receiver state
   sfr_pkg::phase_type phase_ff, phase_in;
   logic [15:0]   sync_shift_ff, sync_shift_in;
   logic [IW-1:0] byte_index_ff, byte_index_in;
   logic [LW-1:0] bytes_left_ff, bytes_left_in;
   logic [15:0]   xor_ff, xor_in;
   logic [15:0]   fail_ff, fail_in;
   logic [IW-1:0] hwm_ff, hwm_in;       // buffer prefix written since last release
   logic [7:0]    sync_lo_ff, sync_lo_in;
   logic [7:0]    sync_hi_ff, sync_hi_in;
   logic [7:0]    id_ff, id_in;
   logic [15:0]   len_ff, len_in;
   logic [IW-1:0] mix_end_ff, mix_end_in;
   logic [7:0]    prev_ff, prev_in;

   // read stage
   logic          s1_valid_ff, s1_valid_in;
   logic [2:0]    s1_kind_ff, s1_kind_in;
   logic [7:0]    s1_id_ff, s1_id_in;
   logic [15:0]   s1_len_ff, s1_len_in;
   logic [15:0]   s1_err_ff, s1_err_in;
   logic          s1_use_mem_ff, s1_use_mem_in;
   logic [7:0]    s1_fix_ff, s1_fix_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_kind_ff;
   logic [7:0]    rsp_id_ff;
   logic [15:0]   rsp_len_ff;
   logic [7:0]    rsp_data_ff;
   logic [15:0]   rsp_err_ff;

   // buffer port
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_q;

   logic          accept;
   logic          s1_move;
   logic [7:0]    b;
   logic [IW-1:0] k_inc;
   logic [15:0]   shift_nx;
   logic          sync_hit;
   logic [15:0]   xor_mixed;
   logic [15:0]   body_xor;
   logic [7:0]    id_nx;
   logic [15:0]   len_nx;
   logic [7:0]    lim;
   logic          too_long;
   logic          hdr_last;
   logic          body_last;
   logic          csum_ok;
   logic          read_hit;
   logic [IW-1:0] hwm_wr;

   assign b         = req_rx_byte;
   assign s1_move   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign k_inc     = byte_index_ff + 1'b1;
   assign shift_nx  = {b, sync_shift_ff[15:8]};
   assign sync_hit  = (shift_nx == sync_word_ff);
   assign xor_mixed = byte_index_ff[0] ? (xor_ff ^ {b, 8'h00}) : (xor_ff ^ {8'h00, b});
   assign body_xor  = (byte_index_ff < mix_end_ff) ? xor_mixed : xor_ff;
   assign id_nx     = (byte_index_ff == ID_IDX) ? b : id_ff;
   assign len_nx[7:0]  = (byte_index_ff == LEN_LO_IDX) ? b : len_ff[7:0];
   assign len_nx[15:8] = (byte_index_ff == LEN_HI_IDX) ? b : len_ff[15:8];
   assign lim       = (max_len_ff < BODY_CAP) ? max_len_ff : BODY_CAP;
   assign too_long  = len_nx > {8'h00, lim};
   assign hdr_last  = (byte_index_ff == HDR_LAST);
   assign body_last = (bytes_left_ff == LW'(1));
   // the final byte is the checksum high half; the one before is its low half
   assign csum_ok   = ({b, prev_ff} == body_xor);
   assign read_hit  = req_read_offset < 8'(hwm_ff);
   assign hwm_wr    = (k_inc > hwm_ff) ? k_inc : hwm_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (req_type)
            sfr_pkg::REQ_RELEASE: begin
               phase_in = sfr_pkg::PH_HUNT;
            end
            sfr_pkg::REQ_BYTE: begin
               case (phase_ff)
                  sfr_pkg::PH_HUNT: begin
                     if (sync_hit) begin
                        phase_in = sfr_pkg::PH_HEADER;
                     end
                  end
                  sfr_pkg::PH_HEADER: begin
                     if (hdr_last) begin
                        phase_in = too_long ? sfr_pkg::PH_HUNT : sfr_pkg::PH_BODY;
                     end
                  end
                  sfr_pkg::PH_BODY: begin
                     if (body_last) begin
                        phase_in = csum_ok ? sfr_pkg::PH_LOCKED : sfr_pkg::PH_HUNT;
                     end
                  end
                  sfr_pkg::PH_LOCKED: begin
                     phase_in = sfr_pkg::PH_LOCKED;
                  end
                  default: begin
                     phase_in = sfr_pkg::PH_HUNT;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // datapath and result generation
   always_comb begin
      sync_shift_in = sync_shift_ff;
      byte_index_in = byte_index_ff;
      bytes_left_in = bytes_left_ff;
      xor_in        = xor_ff;
      fail_in       = fail_ff;
      hwm_in        = hwm_ff;
      sync_lo_in    = sync_lo_ff;
      sync_hi_in    = sync_hi_ff;
      id_in         = id_ff;
      len_in        = len_ff;
      mix_end_in    = mix_end_ff;
      prev_in       = prev_ff;
      mem_we        = 1'b0;
      mem_waddr     = byte_index_ff[AW-1:0];
      mem_re        = 1'b0;
      mem_raddr     = req_read_offset[AW-1:0];
      s1_kind_in    = s1_kind_ff;
      s1_id_in      = id_ff;
      s1_len_in     = len_ff;
      s1_err_in     = fail_ff;
      s1_use_mem_in = 1'b0;
      s1_fix_in     = 8'h00;
      s1_valid_in   = s1_move ? 1'b0 : s1_valid_ff;

      if (accept) begin
         case (req_type)
            sfr_pkg::REQ_READ: begin
               s1_valid_in = 1'b1;
               s1_kind_in  = sfr_pkg::EV_READ;
               if (read_hit) begin
                  if (req_read_offset < SYNC_OFF) begin
                     s1_fix_in = req_read_offset[0] ? sync_hi_ff : sync_lo_ff;
                  end else begin
                     s1_use_mem_in = 1'b1;
                     mem_re        = 1'b1;
                  end
               end
            end
            sfr_pkg::REQ_RELEASE: begin
               byte_index_in = '0;
               bytes_left_in = '0;
               xor_in        = '0;
               hwm_in        = '0;
               id_in         = 8'h00;
               len_in        = 16'h0000;
            end
            sfr_pkg::REQ_BYTE: begin
               case (phase_ff)
                  sfr_pkg::PH_HUNT: begin
                     sync_shift_in = shift_nx;
                     if (sync_hit) begin
                        sync_lo_in    = shift_nx[7:0];
                        sync_hi_in    = shift_nx[15:8];
                        byte_index_in = SYNC_IDX;
                        xor_in        = '0;
                        hwm_in        = (hwm_ff > SYNC_IDX) ? hwm_ff : SYNC_IDX;
                     end
                  end
                  sfr_pkg::PH_HEADER: begin
                     mem_we        = 1'b1;
                     hwm_in        = hwm_wr;
                     id_in         = id_nx;
                     len_in        = len_nx;
                     xor_in        = xor_mixed;
                     byte_index_in = k_inc;
                     if (hdr_last) begin
                        if (too_long) begin
                           byte_index_in = '0;
                           bytes_left_in = '0;
                           sync_shift_in = 16'h0000;
                           s1_valid_in   = 1'b1;
                           s1_kind_in    = sfr_pkg::EV_LONG;
                           s1_id_in      = id_nx;
                           s1_len_in     = len_nx;
                        end else begin
                           bytes_left_in = len_nx[LW-1:0] + LW'(sfr_pkg::CHECK_BYTES);
                           // odd length: first checksum byte joins the XOR
                           mix_end_in    = HDR_BYTES + len_nx[IW-1:0] + IW'(len_nx[0]);
                        end
                     end
                  end
                  sfr_pkg::PH_BODY: begin
                     mem_we        = 1'b1;
                     hwm_in        = hwm_wr;
                     xor_in        = body_xor;
                     prev_in       = b;
                     byte_index_in = k_inc;
                     bytes_left_in = bytes_left_ff - 1'b1;
                     if (body_last) begin
                        s1_valid_in = 1'b1;
                        if (csum_ok) begin
                           byte_index_in = '0;
                           s1_kind_in    = sfr_pkg::EV_GOOD;
                        end else begin
                           if (fail_ff != 16'hFFFF) begin
                              fail_in = fail_ff + 1'b1;
                           end
                           byte_index_in = '0;
                           bytes_left_in = '0;
                           sync_shift_in = 16'h0000;
                           s1_kind_in    = sfr_pkg::EV_CSUM;
                           s1_err_in     = (fail_ff != 16'hFFFF) ? fail_ff + 1'b1 : fail_ff;
                        end
                     end
                  end
                  sfr_pkg::PH_LOCKED: begin
                     s1_valid_in = 1'b1;
                     s1_kind_in  = sfr_pkg::EV_REFUSED;
                  end
                  default: begin
                     byte_index_in = '0;
                     bytes_left_in = '0;
                     sync_shift_in = 16'h0000;
                  end
               endcase
            end
            default: begin
               s1_valid_in = s1_move ? 1'b0 : s1_valid_ff;
            end
         endcase
      end
   end

   // configuration writes
   always_comb begin
      sync_word_in = sync_word_ff;
      max_len_in   = max_len_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sfr_pkg::CSR_SYNC_WORD: begin
               sync_word_in = csr_data;
            end
            sfr_pkg::CSR_MAX_BODY_LEN: begin
               max_len_in = csr_data[7:0];
            end
            default: begin
               sync_word_in = sync_word_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff  <= sfr_pkg::SYNC_WORD_RST;
         max_len_ff    <= sfr_pkg::MAX_BODY_LEN_RST;
         phase_ff      <= sfr_pkg::PH_HUNT;
         sync_shift_ff <= 16'h0000;
         byte_index_ff <= '0;
         bytes_left_ff <= '0;
         xor_ff        <= 16'h0000;
         fail_ff       <= 16'h0000;
         hwm_ff        <= '0;
         id_ff         <= 8'h00;
         len_ff        <= 16'h0000;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         sync_word_ff  <= sync_word_in;
         max_len_ff    <= max_len_in;
         phase_ff      <= phase_in;
         sync_shift_ff <= sync_shift_in;
         byte_index_ff <= byte_index_in;
         bytes_left_ff <= bytes_left_in;
         xor_ff        <= xor_in;
         fail_ff       <= fail_in;
         hwm_ff        <= hwm_in;
         id_ff         <= id_in;
         len_ff        <= len_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sync_lo_ff <= sync_lo_in;
      sync_hi_ff <= sync_hi_in;
      mix_end_ff <= mix_end_in;
      prev_ff    <= prev_in;
      if (accept) begin
         s1_kind_ff    <= s1_kind_in;
         s1_id_ff      <= s1_id_in;
         s1_len_ff     <= s1_len_in;
         s1_err_ff     <= s1_err_in;
         s1_use_mem_ff <= s1_use_mem_in;
         s1_fix_ff     <= s1_fix_in;
      end
      if (s1_move) begin
         rsp_kind_ff <= s1_kind_ff;
         rsp_id_ff   <= s1_id_ff;
         rsp_len_ff  <= s1_len_ff;
         rsp_data_ff <= s1_use_mem_ff ? mem_q : s1_fix_ff;
         rsp_err_ff  <= s1_err_ff;
      end
   end

   sfr_store #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (b),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_frame_id    = rsp_id_ff;
   assign rsp_body_length = rsp_len_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_error_total = rsp_err_ff;

endmodule

### dv/sync_frame_receiver_xor_check_test.sv
// Self-checking bench for sync_frame_receiver_xor_check: drives byte, read and
// release words with random gaps and stalls, predicts every result word.
// Depends on sfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module sync_frame_receiver_xor_check_test;
   import sfr_pkg::*;

   localparam int STORE_LEN = HEADER_BYTES + MAX_BODY + CHECK_BYTES;
   localparam int RANDOM_WORDS = 900;
   localparam int SEGMENTS = 5;
   localparam logic [1:0] REQ_NONE = 2'd3;   // unused code, block ignores it

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  frame_id;
      logic [15:0] body_length;
      logic [7:0]  read_data;
      logic [15:0] error_total;
   } frame_event_t;

   // Tracks the receiver state word by word and holds the results still due.
   class frame_event_model;
      logic [15:0]  sync_word;
      logic [7:0]   len_reg;
      phase_type    phase;
      logic [15:0]  sync_shift;
      logic [7:0]   byte_index;
      logic [16:0]  bytes_left;
      logic [15:0]  running_xor;
      logic [15:0]  fail_count;
      logic [7:0]   buffer [STORE_LEN];
      frame_event_t due_events [$];
      int           mismatches;
      int           checked;
      int           tally [5];

      function new();
         sync_word = SYNC_WORD_RST;
         len_reg = MAX_BODY_LEN_RST;
         phase = PH_HUNT;
         sync_shift = '0;
         byte_index = '0;
         bytes_left = '0;
         running_xor = '0;
         fail_count = '0;
         mismatches = 0;
         checked = 0;
         foreach (tally[i]) tally[i] = 0;
         wipe_buffer();
      endfunction

      function void wipe_buffer();
         foreach (buffer[i]) buffer[i] = 8'h00;
      endfunction

      function void write_reg(logic [1:0] index, logic [15:0] value);
         if (index == CSR_SYNC_WORD) sync_word = value;
         else if (index == CSR_MAX_BODY_LEN) len_reg = value[7:0];
      endfunction

      function logic [15:0] length_field();
         return {buffer[LENGTH_OFFSET + 1], buffer[LENGTH_OFFSET]};
      endfunction

      // odd offsets are the high half of a little-endian word
      function void fold_byte(int pos, logic [7:0] b);
         running_xor ^= pos[0] ? {b, 8'h00} : {8'h00, b};
      endfunction

      function void abandon_frame();
         phase = PH_HUNT;
         byte_index = '0;
         bytes_left = '0;
         sync_shift = '0;
      endfunction

      function void post_event(logic [2:0] kind, logic [7:0] data);
         frame_event_t ev;
         ev.kind = kind;
         ev.frame_id = buffer[ID_OFFSET];
         ev.body_length = length_field();
         ev.read_data = data;
         ev.error_total = fail_count;
         due_events.push_back(ev);
      endfunction

      function void note_request(logic [1:0] req, logic [7:0] b, logic [7:0] offset);
         int lim;
         int pos;
         int dlen;
         int tail;
         logic [15:0] rcv;
         lim = (len_reg < MAX_BODY) ? len_reg : MAX_BODY;
         case (req)
            REQ_READ: post_event(EV_READ, (offset < STORE_LEN) ? buffer[offset] : 8'h00);
            REQ_RELEASE: begin
               wipe_buffer();
               phase = PH_HUNT;
               byte_index = '0;
               bytes_left = '0;
               running_xor = '0;
            end
            REQ_BYTE: begin
               case (phase)
                  PH_LOCKED: post_event(EV_REFUSED, 8'h00);
                  PH_HUNT: begin
                     sync_shift = {b, sync_shift[15:8]};
                     if (sync_shift == sync_word) begin
                        buffer[0] = sync_shift[7:0];
                        buffer[1] = sync_shift[15:8];
                        byte_index = 8'(SYNC_BYTES);
                        running_xor = '0;
                        phase = PH_HEADER;
                     end
                  end
                  PH_HEADER: begin
                     pos = byte_index;
                     buffer[pos] = b;
                     fold_byte(pos, b);
                     byte_index = byte_index + 8'd1;
                     if (byte_index >= HEADER_BYTES) begin
                        dlen = length_field();
                        if (dlen > lim) begin
                           abandon_frame();
                           post_event(EV_LONG, 8'h00);
                        end else begin
                           bytes_left = 17'(dlen + CHECK_BYTES);
                           phase = PH_BODY;
                        end
                     end
                  end
                  PH_BODY: begin
                     pos = byte_index;
                     dlen = length_field();
                     if (pos < STORE_LEN) buffer[pos] = b;
                     // odd length: first check byte closes the last word
                     if (pos < HEADER_BYTES + dlen + dlen % 2) fold_byte(pos, b);
                     byte_index = byte_index + 8'd1;
                     if (bytes_left > 0) bytes_left = bytes_left - 17'd1;
                     if (bytes_left == 0) begin
                        tail = HEADER_BYTES + dlen;
                        rcv = (tail + 1 < STORE_LEN) ? {buffer[tail + 1], buffer[tail]} : 16'h0;
                        if (rcv == running_xor) begin
                           phase = PH_LOCKED;
                           byte_index = '0;
                           post_event(EV_GOOD, 8'h00);
                        end else begin
                           if (fail_count != 16'hFFFF) fail_count = fail_count + 16'd1;
                           abandon_frame();
                           post_event(EV_CSUM, 8'h00);
                        end
                     end
                  end
                  default: abandon_frame();
               endcase
            end
            default: ;
         endcase
      endfunction

      function void check_event(frame_event_t got);
         frame_event_t want;
         if (due_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: kind %0d id %02h len %0d data %02h errs %0d",
                        got.kind, got.frame_id, got.body_length, got.read_data,
                        got.error_total);
            return;
         end
         want = due_events.pop_front();
         checked++;
         if (want.kind < 5) tally[want.kind]++;
         if (got.kind !== want.kind || got.frame_id !== want.frame_id ||
             got.body_length !== want.body_length || got.read_data !== want.read_data ||
             got.error_total !== want.error_total) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected kind %0d id %02h len %0d data %02h errs %0d, %s",
                        want.kind, want.frame_id, want.body_length, want.read_data,
                        want.error_total,
                        $sformatf("got kind %0d id %02h len %0d data %02h errs %0d",
                                  got.kind, got.frame_id, got.body_length,
                                  got.read_data, got.error_total));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic [7:0]  req_read_offset = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [7:0]  rsp_frame_id;
   logic [15:0] rsp_body_length;
   logic [7:0]  rsp_read_data;
   logic [15:0] rsp_error_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SYNC_WORD;
   logic [15:0] csr_data = 16'h0000;

   frame_event_model sb = new();
   bit          idle_on = 1'b1;
   int          rsp_hold_cycles = 0;   // long receiver hold-off, counted down by the sink
   int          words_sent = 0;
   logic [15:0] cur_sync = SYNC_WORD_RST;
   int          len_limit = MAX_BODY;

   sync_frame_receiver_xor_check i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_rx_byte     (req_rx_byte),
      .req_read_offset (req_read_offset),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_frame_id    (rsp_frame_id),
      .rsp_body_length (rsp_body_length),
      .rsp_read_data   (rsp_read_data),
      .rsp_error_total (rsp_error_total),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // result side: check each accepted word, then stall a random while
   initial begin : result_sink
      int stall_left;
      frame_event_t got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got.kind = rsp_event_kind;
            got.frame_id = rsp_frame_id;
            got.body_length = rsp_body_length;
            got.read_data = rsp_read_data;
            got.error_total = rsp_error_total;
            sb.check_event(got);
            stall_left = idle_on ? $urandom_range(0, 5) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         if (rsp_hold_cycles > 0) rsp_hold_cycles--;
         rsp_stall <= (stall_left > 0) || (rsp_hold_cycles > 0);
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_word(input logic [1:0] kind, input logic [7:0] rx,
                            input logic [7:0] offset);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_rx_byte <= rx;
      req_read_offset <= offset;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, rx, offset);
      if (kind != REQ_NONE) words_sent++;
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(index, value);
      if (index == CSR_SYNC_WORD) cur_sync = value;
      else if (index == CSR_MAX_BODY_LEN) len_limit = (value[7:0] < MAX_BODY) ? value[7:0] : MAX_BODY;
      @(posedge clock);
   endtask

   // hold the sender until every due result is back, then let the pipe settle
   task automatic drain(input int settle);
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.due_events.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (settle) @(posedge clock);
   endtask

   // sync, header, then body and check word only when the length is within the limit
   task automatic send_frame(input logic [15:0] body_len, input bit good_sum, input bit cut);
      logic [7:0] frame_bytes [$];
      logic [15:0] sum;
      logic [15:0] tail_sum;
      int stop;
      frame_bytes = {};
      frame_bytes.push_back(cur_sync[7:0]);
      frame_bytes.push_back(cur_sync[15:8]);
      frame_bytes.push_back(rand_byte());
      frame_bytes.push_back(rand_byte());
      frame_bytes.push_back(body_len[7:0]);
      frame_bytes.push_back(body_len[15:8]);
      frame_bytes.push_back(rand_byte());
      frame_bytes.push_back(rand_byte());
      if (body_len <= len_limit) begin
         for (int i = 0; i < body_len; i++) frame_bytes.push_back(rand_byte());
         sum = '0;
         for (int i = SYNC_BYTES; i < frame_bytes.size(); i++)
            sum ^= i[0] ? {frame_bytes[i], 8'h00} : {8'h00, frame_bytes[i]};
         tail_sum[7:0] = sum[7:0];
         tail_sum[15:8] = body_len[0] ? sum[15:8] ^ sum[7:0] : sum[15:8];
         if (!good_sum) tail_sum ^= 16'($urandom_range(1, 65535));
         frame_bytes.push_back(tail_sum[7:0]);
         frame_bytes.push_back(tail_sum[15:8]);
      end
      stop = cut ? $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
      for (int i = 0; i < stop; i++) push_word(REQ_BYTE, frame_bytes[i], rand_byte());
      if (cut) push_word(REQ_RELEASE, rand_byte(), rand_byte());
   endtask

   task automatic random_sequence();
      int roll;
      int n;
      int hi;
      logic [15:0] blen;
      if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         n = $urandom_range(1, 4);
         repeat (n) push_word(2'($urandom_range(0, 3)), rand_byte(), rand_byte());
         return;
      end
      if (sb.phase != PH_HUNT) push_word(REQ_RELEASE, rand_byte(), rand_byte());
      n = $urandom_range(0, 2);
      repeat (n) push_word(REQ_BYTE, rand_byte(), rand_byte());
      roll = $urandom_range(0, 99);
      if (roll < 10) blen = 16'($urandom_range(len_limit + 1, 65535));
      else if (roll < 15) blen = 16'($urandom_range(0, len_limit));
      else blen = 16'($urandom_range(0, (len_limit < 12) ? len_limit : 12));
      send_frame(blen, $urandom_range(0, 3) != 0, $urandom_range(0, 19) == 0);
      if (sb.phase == PH_LOCKED) begin
         hi = HEADER_BYTES + sb.length_field() + 1;
         if (hi > 255) hi = 255;
         n = $urandom_range(1, 4);
         repeat (n) begin
            roll = $urandom_range(0, 9);
            if (roll < 8) push_word(REQ_READ, rand_byte(), 8'($urandom_range(0, hi)));
            else if (roll < 9) push_word(REQ_READ, rand_byte(), 8'($urandom_range(STORE_LEN, 255)));
            else push_word(REQ_READ, rand_byte(), rand_byte());
         end
         if ($urandom_range(0, 2) == 0) push_word(REQ_BYTE, rand_byte(), rand_byte());
         push_word(REQ_RELEASE, rand_byte(), rand_byte());
      end
   endtask

   initial begin : stimulus
      int target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(CSR_SYNC_WORD, 16'hA55A);
      write_csr(CSR_MAX_BODY_LEN, 16'd128);
      // buffer is undefined out of reset; a release makes every entry read zero
      push_word(REQ_RELEASE, 8'h00, 8'h00);
      push_word(REQ_READ, 8'h00, 8'hFF);
      push_word(REQ_NONE, 8'hFF, 8'hFF);
      send_frame(16'd1, 1'b1, 1'b0);
      push_word(REQ_BYTE, 8'hFF, 8'h00);
      push_word(REQ_READ, 8'h00, 8'(ID_OFFSET));
      push_word(REQ_RELEASE, 8'hFF, 8'h00);
      send_frame(16'hFFFF, 1'b1, 1'b0);

      // limit register above MAX_BODY is clipped to MAX_BODY
      drain(4);
      write_csr(CSR_MAX_BODY_LEN, 16'h00FF);
      send_frame(16'(MAX_BODY + 1), 1'b1, 1'b0);
      send_frame(16'(MAX_BODY), 1'b1, 1'b0);
      push_word(REQ_READ, 8'h00, 8'(STORE_LEN - 1));
      push_word(REQ_RELEASE, 8'h00, 8'h00);

      drain(4);
      write_csr(CSR_SYNC_WORD, 16'h0000);
      write_csr(CSR_MAX_BODY_LEN, 16'd0);
      send_frame(16'd0, 1'b0, 1'b0);
      send_frame(16'd0, 1'b1, 1'b0);
      push_word(REQ_RELEASE, 8'h00, 8'h00);
      send_frame(16'd1, 1'b1, 1'b0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain(4);
         idle_on = 1'b1;
         case (seg)
            0: begin
               write_csr(CSR_SYNC_WORD, 16'($urandom_range(0, 65535)));
               write_csr(CSR_MAX_BODY_LEN, 16'd128);
            end
            1: begin
               write_csr(CSR_SYNC_WORD, 16'hFFFF);
               write_csr(CSR_MAX_BODY_LEN, 16'($urandom_range(0, 128)));
            end
            2: begin
               write_csr(CSR_SYNC_WORD, 16'($urandom_range(0, 65535)));
               write_csr(CSR_MAX_BODY_LEN, 16'd1);
            end
            3: begin
               write_csr(CSR_SYNC_WORD, 16'($urandom_range(0, 65535)));
               write_csr(CSR_MAX_BODY_LEN, 16'($urandom_range(0, 128)));
               // receiver goes quiet while reads keep coming: fills the pipe
               rsp_hold_cycles = 60;
               repeat (20) push_word(REQ_READ, rand_byte(), rand_byte());
               drain(4);
            end
            default: begin
               write_csr(CSR_SYNC_WORD, 16'($urandom_range(0, 65535)));
               write_csr(CSR_MAX_BODY_LEN, 16'd64);
            end
         endcase
         target = words_sent + RANDOM_WORDS / SEGMENTS;
         while (words_sent < target) random_sequence();
      end

      drain(8);
      $display("Sent %0d request words through %0d register settings, %0d results checked.",
               words_sent, SEGMENTS + 3, sb.checked);
      $display("Events: %0d good, %0d checksum, %0d too long, %0d reads, %0d refused.",
               sb.tally[EV_GOOD], sb.tally[EV_CSUM], sb.tally[EV_LONG], sb.tally[EV_READ],
               sb.tally[EV_REFUSED]);
      if (sb.mismatches == 0 && sb.due_events.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
